@@ hw/rtl/sm4_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sm4_pkg
// Shared constants and round functions of the SM4 cipher: altered S-box ROM,
// FK system parameters, CK generation and the two linear transforms.
// ----------------------------------------------------------------------------
package sm4_pkg;

	localparam int ROUNDS = 32;
	localparam int RK_IDX_W = $clog2(ROUNDS);

	typedef logic [ROUNDS-1:0][31:0] rk_arr_t;

	// FK system parameters
	localparam logic [31:0] FK0 = 32'hA3B1BAC6;
	localparam logic [31:0] FK1 = 32'h56AA3350;
	localparam logic [31:0] FK2 = 32'h677D9197;
	localparam logic [31:0] FK3 = 32'hB27022DC;

	// S-box ROM, entry 0 swapped around with ten other entries
	localparam logic [7:0] SBOX [256] = '{
		8'hD1, 8'h90, 8'hE9, 8'hFE, 8'hCC, 8'hE1, 8'h3D, 8'hB7,
		8'h16, 8'hB6, 8'h14, 8'hC2, 8'h28, 8'hFB, 8'h2C, 8'h05,
		8'h2B, 8'h67, 8'h9A, 8'h76, 8'h2A, 8'hBE, 8'h04, 8'hC3,
		8'hAA, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
		8'h9C, 8'h42, 8'h50, 8'hF4, 8'h91, 8'hEF, 8'h98, 8'h7A,
		8'h33, 8'h54, 8'h0B, 8'h43, 8'hED, 8'hCF, 8'hAC, 8'h62,
		8'hE4, 8'hB3, 8'h17, 8'hA9, 8'h1C, 8'h08, 8'hE8, 8'h95,
		8'h80, 8'hDF, 8'h94, 8'hFA, 8'h75, 8'h8F, 8'h3F, 8'hA6,
		8'h47, 8'h07, 8'hA7, 8'h4F, 8'hF3, 8'h73, 8'h71, 8'hBA,
		8'h83, 8'h59, 8'h3C, 8'h19, 8'hE6, 8'h85, 8'hD6, 8'hA8,
		8'h68, 8'h6B, 8'h81, 8'hB2, 8'hFC, 8'h64, 8'hDA, 8'h8B,
		8'hF8, 8'hEB, 8'h0F, 8'h4B, 8'h70, 8'h56, 8'h9D, 8'h35,
		8'h1E, 8'h24, 8'h0E, 8'h78, 8'h63, 8'h58, 8'h9F, 8'hA2,
		8'h25, 8'h22, 8'h7C, 8'h3B, 8'h01, 8'h21, 8'hC9, 8'h87,
		8'hD4, 8'h00, 8'h46, 8'h57, 8'h5E, 8'hD3, 8'h27, 8'h52,
		8'h4C, 8'h36, 8'h02, 8'hE7, 8'hA0, 8'hC4, 8'hC8, 8'h9E,
		8'hEA, 8'hBF, 8'h8A, 8'hD2, 8'h40, 8'hC7, 8'h38, 8'hB5,
		8'hA3, 8'hF7, 8'hF2, 8'hCE, 8'hF9, 8'h61, 8'h15, 8'hA1,
		8'hE0, 8'hAE, 8'h5D, 8'hA4, 8'h9B, 8'h34, 8'h1A, 8'h55,
		8'hAD, 8'h93, 8'h32, 8'h30, 8'hF5, 8'h8C, 8'hB1, 8'hE3,
		8'h1D, 8'hF6, 8'hE2, 8'h2E, 8'h82, 8'h66, 8'hCA, 8'h60,
		8'hC0, 8'h29, 8'h23, 8'hAB, 8'h0D, 8'h53, 8'h4E, 8'h6F,
		8'hD5, 8'hDB, 8'h37, 8'h45, 8'hDE, 8'hFD, 8'h8E, 8'h2F,
		8'h03, 8'hFF, 8'h6A, 8'h72, 8'h6D, 8'h6C, 8'h5B, 8'h51,
		8'h8D, 8'h1B, 8'hAF, 8'h92, 8'hBB, 8'hDD, 8'hBC, 8'h7F,
		8'h11, 8'hD9, 8'h5C, 8'h41, 8'h1F, 8'h10, 8'h5A, 8'hD8,
		8'h0A, 8'hC1, 8'h31, 8'h88, 8'hA5, 8'hCD, 8'h7B, 8'hBD,
		8'h2D, 8'h74, 8'hD0, 8'h12, 8'hB8, 8'hE5, 8'hB4, 8'hB0,
		8'h89, 8'h69, 8'h97, 8'h4A, 8'h0C, 8'h96, 8'h77, 8'h7E,
		8'h65, 8'hB9, 8'hF1, 8'h09, 8'hC5, 8'h6E, 8'hC6, 8'h84,
		8'h18, 8'hF0, 8'h7D, 8'hEC, 8'h3A, 8'hDC, 8'h4D, 8'h20,
		8'h79, 8'hEE, 8'h5F, 8'h3E, 8'hD7, 8'hCB, 8'h39, 8'h48
	};

	// byte-wise S-box substitution
	function automatic logic [31:0] tau(input logic [31:0] v);
		return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
	endfunction

	// data path transform L
	function automatic logic [31:0] l_data(input logic [31:0] t);
		return t ^ {t[29:0], t[31:30]} ^ {t[21:0], t[31:22]}
			^ {t[13:0], t[31:14]} ^ {t[7:0], t[31:8]};
	endfunction

	// key schedule transform L'
	function automatic logic [31:0] l_key(input logic [31:0] t);
		return t ^ {t[18:0], t[31:19]} ^ {t[8:0], t[31:9]};
	endfunction

	// CK constant: byte k of word i is 7*(4i+k) mod 256
	function automatic logic [31:0] ck_word(input logic [RK_IDX_W-1:0] i);
		logic [7:0] base;
		base = {1'b0, i, 2'b00};
		return {8'(base * 8'd7), 8'((base + 8'd1) * 8'd7),
			8'((base + 8'd2) * 8'd7), 8'((base + 8'd3) * 8'd7)};
	endfunction

endpackage
`default_nettype wire

@@ hw/rtl/sm4_block_cipher_custom_sbox.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sm4_block_cipher_custom_sbox
// SM4 encrypt/decrypt engine, one round per pipeline stage, altered S-box.
//
//   channel  handshake                  payload
//   data     data_valid / data_stall    mode, data_high, data_low
//   result   result_valid/result_stall  result_high, result_low
//   config   APB (psel/penable/...)     key_high @0x0, key_low @0x8
//
// One word per cycle while neither key expansion nor a stalled result holds the
// flow; each word passes through the 32 round stages. After reset and after every
// key write the key schedule runs again (one round key per cycle); data_stall is high during that time.
// A stalled result freezes the whole round pipeline; nothing moves or drops.
// ----------------------------------------------------------------------------
module sm4_block_cipher_custom_sbox (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// data channel
	input  wire logic        data_valid,
	output logic             data_stall,
	input  wire logic        mode,
	input  wire logic [63:0] data_high,
	input  wire logic [63:0] data_low,
	// result channel
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [63:0]      result_high,
	output logic [63:0]      result_low,
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic [63:0]      prdata,
	output logic             pready
);

	localparam int R = sm4_pkg::ROUNDS;

	logic             key_write;
	logic [63:0]      key_high_q, key_low_q;
	logic             key_busy;
	sm4_pkg::rk_arr_t rk;
	logic             advance;
	logic             accept;

	logic [R:1]       valid_s;
	logic [R:1]       mode_s;
	logic [127:0]     state_s [R:1];

	logic [R-1:0]     st_mode;
	logic [127:0]     st_in  [R];
	logic [127:0]     st_out [R];

	// register file
	assign pready    = 1'b1;
	assign key_write = psel & penable & pwrite;
	assign prdata    = paddr[3] ? key_low_q : key_high_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
		end else if (key_write) begin
			if (paddr[3]) begin
				key_low_q <= pwdata;
			end else begin
				key_high_q <= pwdata;
			end
		end
	end

	sm4_key_sched u_key_sched (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_write (key_write),
		.key       ({key_high_q, key_low_q}),
		.busy      (key_busy),
		.rk        (rk)
	);

	// handshake: the pipe moves unless a finished word is held
	assign advance    = !(valid_s[R] && result_stall);
	assign data_stall = key_busy | !advance;
	assign accept     = data_valid & !data_stall;

	// round stages
	assign st_in[0]   = {data_high, data_low};
	assign st_mode[0] = mode;

	for (genvar r = 0; r < R; r++) begin : g_round
		if (r > 0) begin : g_tap
			assign st_in[r]   = state_s[r];
			assign st_mode[r] = mode_s[r];
		end

		sm4_round u_round (
			.state_in  (st_in[r]),
			.rk        (st_mode[r] ? rk[R-1-r] : rk[r]),
			.state_out (st_out[r])
		);

		always_ff @(posedge clk) begin
			if (advance) begin
				state_s[r+1] <= st_out[r];
				mode_s[r+1]  <= st_mode[r];
			end
		end
	end

	// valid bits travel with the words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (advance) begin
			valid_s <= {valid_s[R-1:1], accept};
		end
	end

	// output: word order reversed
	assign result_valid = valid_s[R];
	assign result_high  = {state_s[R][31:0], state_s[R][63:32]};
	assign result_low   = {state_s[R][95:64], state_s[R][127:96]};

	// an accepted word lands in the first stage
	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s[1])
		else $error("accepted word missing from first stage");

	// no word enters while round keys are being rebuilt
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		key_busy |-> !valid_s[1] || $past(valid_s[1]) || !$past(advance))
		else $error("word entered during key expansion");

	// a result appears only from the stage before it
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s[R]) |-> $past(valid_s[R-1]))
		else $error("result valid without a word behind it");

endmodule
`default_nettype wire

@@ hw/rtl/sm4_round.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sm4_round
// One SM4 round: S-box layer, linear transform and word rotation of the state.
// ----------------------------------------------------------------------------
module sm4_round (
	input  wire logic [127:0] state_in,
	input  wire logic [31:0]  rk,
	output logic      [127:0] state_out
);

	logic [31:0] x0, x1, x2, x3;
	logic [31:0] t;

	assign {x0, x1, x2, x3} = state_in;

	// F function
	assign t = sm4_pkg::tau(x1 ^ x2 ^ x3 ^ rk);
	assign state_out = {x1, x2, x3, x0 ^ sm4_pkg::l_data(t)};

endmodule
`default_nettype wire

@@ hw/rtl/sm4_key_sched.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sm4_key_sched
// Iterative key expansion: one round key per cycle into a round-key register
// file. Restarts after reset and on every key write.
// ----------------------------------------------------------------------------
module sm4_key_sched (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             key_write,
	input  wire logic [127:0]     key,
	output logic                  busy,
	output sm4_pkg::rk_arr_t      rk
);

	logic                          kick_q;
	logic                          run_q;
	logic [sm4_pkg::RK_IDX_W-1:0]  cnt_q;
	logic [127:0]                  kw_q;
	sm4_pkg::rk_arr_t              rk_q;
	logic [31:0]                   k0, k1, k2, k3;
	logic [31:0]                   nk;

	assign {k0, k1, k2, k3} = kw_q;
	assign nk = k0 ^ sm4_pkg::l_key(sm4_pkg::tau(k1 ^ k2 ^ k3 ^ sm4_pkg::ck_word(cnt_q)));

	// control: a kick loads the key, then expansion runs up to the last round key
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kick_q <= 1'b1;
			run_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			kick_q <= key_write;
			if (kick_q) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == sm4_pkg::RK_IDX_W'(sm4_pkg::ROUNDS - 1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	// key words and round-key file
	always_ff @(posedge clk) begin
		if (kick_q) begin
			kw_q <= key ^ {sm4_pkg::FK0, sm4_pkg::FK1, sm4_pkg::FK2, sm4_pkg::FK3};
		end else if (run_q) begin
			kw_q        <= {k1, k2, k3, nk};
			rk_q[cnt_q] <= nk;
		end
	end

	assign busy = kick_q | run_q;
	assign rk   = rk_q;

	// a kick always follows a key write
	a_write_kicks: assert property (@(posedge clk) disable iff (!arst_n)
		key_write |=> kick_q)
		else $error("key write did not restart expansion");

	// expansion ends exactly after the last round key
	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(run_q) |-> $past(cnt_q) == sm4_pkg::RK_IDX_W'(sm4_pkg::ROUNDS - 1))
		else $error("expansion stopped early");

endmodule
`default_nettype wire

@@ dv/sm4_block_cipher_custom_sbox_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm4_block_cipher_custom_sbox_tb
// Self-checking bench for the SM4 engine with the altered S-box. Blocks are
// pushed through the data channel in both modes under several keys. A local
// SM4 model works out each ciphertext/plaintext when a word is accepted. Each
// result word is checked half by half against the oldest pending one. Sender
// gaps and receiver stalls are varied phase by phase.
// ----------------------------------------------------------------------------
module sm4_block_cipher_custom_sbox_tb;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 40;
	localparam int MAX_PRINTED = 20;

	localparam logic MODE_ENCRYPT = 1'b0;
	localparam logic MODE_DECRYPT = 1'b1;

	localparam logic [3:0] ADDR_KEY_HIGH = 4'h0;
	localparam logic [3:0] ADDR_KEY_LOW  = 4'h8;

	localparam logic [31:0] SYS_PARAM [4] = '{
		32'hA3B1BAC6, 32'h56AA3350, 32'h677D9197, 32'hB27022DC
	};

	// altered substitution table
	localparam logic [7:0] SUB_TABLE [256] = '{
		8'hD1, 8'h90, 8'hE9, 8'hFE, 8'hCC, 8'hE1, 8'h3D, 8'hB7,
		8'h16, 8'hB6, 8'h14, 8'hC2, 8'h28, 8'hFB, 8'h2C, 8'h05,
		8'h2B, 8'h67, 8'h9A, 8'h76, 8'h2A, 8'hBE, 8'h04, 8'hC3,
		8'hAA, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
		8'h9C, 8'h42, 8'h50, 8'hF4, 8'h91, 8'hEF, 8'h98, 8'h7A,
		8'h33, 8'h54, 8'h0B, 8'h43, 8'hED, 8'hCF, 8'hAC, 8'h62,
		8'hE4, 8'hB3, 8'h17, 8'hA9, 8'h1C, 8'h08, 8'hE8, 8'h95,
		8'h80, 8'hDF, 8'h94, 8'hFA, 8'h75, 8'h8F, 8'h3F, 8'hA6,
		8'h47, 8'h07, 8'hA7, 8'h4F, 8'hF3, 8'h73, 8'h71, 8'hBA,
		8'h83, 8'h59, 8'h3C, 8'h19, 8'hE6, 8'h85, 8'hD6, 8'hA8,
		8'h68, 8'h6B, 8'h81, 8'hB2, 8'hFC, 8'h64, 8'hDA, 8'h8B,
		8'hF8, 8'hEB, 8'h0F, 8'h4B, 8'h70, 8'h56, 8'h9D, 8'h35,
		8'h1E, 8'h24, 8'h0E, 8'h78, 8'h63, 8'h58, 8'h9F, 8'hA2,
		8'h25, 8'h22, 8'h7C, 8'h3B, 8'h01, 8'h21, 8'hC9, 8'h87,
		8'hD4, 8'h00, 8'h46, 8'h57, 8'h5E, 8'hD3, 8'h27, 8'h52,
		8'h4C, 8'h36, 8'h02, 8'hE7, 8'hA0, 8'hC4, 8'hC8, 8'h9E,
		8'hEA, 8'hBF, 8'h8A, 8'hD2, 8'h40, 8'hC7, 8'h38, 8'hB5,
		8'hA3, 8'hF7, 8'hF2, 8'hCE, 8'hF9, 8'h61, 8'h15, 8'hA1,
		8'hE0, 8'hAE, 8'h5D, 8'hA4, 8'h9B, 8'h34, 8'h1A, 8'h55,
		8'hAD, 8'h93, 8'h32, 8'h30, 8'hF5, 8'h8C, 8'hB1, 8'hE3,
		8'h1D, 8'hF6, 8'hE2, 8'h2E, 8'h82, 8'h66, 8'hCA, 8'h60,
		8'hC0, 8'h29, 8'h23, 8'hAB, 8'h0D, 8'h53, 8'h4E, 8'h6F,
		8'hD5, 8'hDB, 8'h37, 8'h45, 8'hDE, 8'hFD, 8'h8E, 8'h2F,
		8'h03, 8'hFF, 8'h6A, 8'h72, 8'h6D, 8'h6C, 8'h5B, 8'h51,
		8'h8D, 8'h1B, 8'hAF, 8'h92, 8'hBB, 8'hDD, 8'hBC, 8'h7F,
		8'h11, 8'hD9, 8'h5C, 8'h41, 8'h1F, 8'h10, 8'h5A, 8'hD8,
		8'h0A, 8'hC1, 8'h31, 8'h88, 8'hA5, 8'hCD, 8'h7B, 8'hBD,
		8'h2D, 8'h74, 8'hD0, 8'h12, 8'hB8, 8'hE5, 8'hB4, 8'hB0,
		8'h89, 8'h69, 8'h97, 8'h4A, 8'h0C, 8'h96, 8'h77, 8'h7E,
		8'h65, 8'hB9, 8'hF1, 8'h09, 8'hC5, 8'h6E, 8'hC6, 8'h84,
		8'h18, 8'hF0, 8'h7D, 8'hEC, 8'h3A, 8'hDC, 8'h4D, 8'h20,
		8'h79, 8'hEE, 8'h5F, 8'h3E, 8'hD7, 8'hCB, 8'h39, 8'h48
	};

	typedef struct packed {
		logic [63:0] high;
		logic [63:0] low;
	} block_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        data_valid;
	logic        data_stall;
	logic        mode;
	logic [63:0] data_high;
	logic [63:0] data_low;
	logic        result_valid;
	logic        result_stall;
	logic [63:0] result_high;
	logic [63:0] result_low;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;

	// local copy of the key registers and the derived round keys
	logic [63:0] key_high_q;
	logic [63:0] key_low_q;
	logic [31:0] round_keys [32];

	block_t      pending_blocks [$];
	int          error_count = 0;
	int unsigned cycle_count = 0;
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;

	sm4_block_cipher_custom_sbox u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.data_valid   (data_valid),
		.data_stall   (data_stall),
		.mode         (mode),
		.data_high    (data_high),
		.data_low     (data_low),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_high  (result_high),
		.result_low   (result_low),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// SM4 model
	// ------------------------------------------------------------------------
	function automatic logic [31:0] sub_word(input logic [31:0] v);
		return {SUB_TABLE[v[31:24]], SUB_TABLE[v[23:16]],
			SUB_TABLE[v[15:8]], SUB_TABLE[v[7:0]]};
	endfunction

	function automatic logic [31:0] rol32(input logic [31:0] v, input int s);
		return (v << s) | (v >> (32 - s));
	endfunction

	// byte k of word i is 7*(4i+k) mod 256
	function automatic logic [31:0] schedule_const(input int i);
		logic [31:0] w;
		w = '0;
		for (int k = 0; k < 4; k++)
			w = {w[23:0], 8'((4 * i + k) * 7)};
		return w;
	endfunction

	function automatic void expand_round_keys();
		logic [31:0] k [4];
		logic [31:0] t;
		logic [31:0] nk;
		k[0] = key_high_q[63:32] ^ SYS_PARAM[0];
		k[1] = key_high_q[31:0] ^ SYS_PARAM[1];
		k[2] = key_low_q[63:32] ^ SYS_PARAM[2];
		k[3] = key_low_q[31:0] ^ SYS_PARAM[3];
		for (int i = 0; i < 32; i++) begin
			t = sub_word(k[1] ^ k[2] ^ k[3] ^ schedule_const(i));
			nk = k[0] ^ t ^ rol32(t, 13) ^ rol32(t, 23);
			k[0] = k[1];
			k[1] = k[2];
			k[2] = k[3];
			k[3] = nk;
			round_keys[i] = nk;
		end
	endfunction

	// decrypt runs the same rounds with the keys reversed
	function automatic block_t sm4_crypt(input logic m, input logic [63:0] hi,
			input logic [63:0] lo);
		logic [31:0] x [4];
		logic [31:0] rk;
		logic [31:0] t;
		logic [31:0] nx;
		block_t      out;
		x[0] = hi[63:32];
		x[1] = hi[31:0];
		x[2] = lo[63:32];
		x[3] = lo[31:0];
		for (int r = 0; r < 32; r++) begin
			rk = (m == MODE_DECRYPT) ? round_keys[31 - r] : round_keys[r];
			t = sub_word(x[1] ^ x[2] ^ x[3] ^ rk);
			nx = x[0] ^ t ^ rol32(t, 2) ^ rol32(t, 10) ^ rol32(t, 18) ^ rol32(t, 24);
			x[0] = x[1];
			x[1] = x[2];
			x[2] = x[3];
			x[3] = nx;
		end
		out.high = {x[3], x[2]};
		out.low = {x[1], x[0]};
		return out;
	endfunction

	// random half block, extremes now and then
	function automatic logic [63:0] rand_half();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return 64'd1 << $urandom_range(63);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------------
	task automatic report_error(input string msg);
		if (error_count < MAX_PRINTED)
			$display("ERROR @%0t: %s", $realtime, msg);
		error_count++;
	endtask

	// receiver stall
	always @(negedge clk) begin
		result_stall <= ($urandom_range(99) < stall_pct);
	end

	// result word checker
	always @(posedge clk) begin
		block_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_blocks.size() == 0) begin
				report_error($sformatf("unexpected result %h %h", result_high, result_low));
			end else begin
				want = pending_blocks.pop_front();
				if (result_high !== want.high)
					report_error($sformatf("result_high %h, want %h",
						result_high, want.high));
				if (result_low !== want.low)
					report_error($sformatf("result_low %h, want %h",
						result_low, want.low));
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL sm4_block_cipher_custom_sbox");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------------
	task automatic send_block(input logic m, input logic [63:0] hi, input logic [63:0] lo);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			data_valid <= 1'b0;
			@(negedge clk);
		end
		data_valid <= 1'b1;
		mode <= m;
		data_high <= hi;
		data_low <= lo;
		do @(posedge clk); while (data_stall);
		pending_blocks.push_back(sm4_crypt(m, hi, lo));
	endtask

	// encrypt a block, then decrypt what came out
	task automatic send_round_trip(input logic [63:0] hi, input logic [63:0] lo);
		block_t ct;
		ct = sm4_crypt(MODE_ENCRYPT, hi, lo);
		send_block(MODE_ENCRYPT, hi, lo);
		send_block(MODE_DECRYPT, ct.high, ct.low);
	endtask

	// every block yields a result, so an empty queue means idle
	task automatic wait_drained();
		@(negedge clk);
		data_valid <= 1'b0;
		while (pending_blocks.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_key_reg(input logic [3:0] addr, input logic [63:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (addr)
			ADDR_KEY_HIGH: key_high_q = value;
			ADDR_KEY_LOW:  key_low_q = value;
			default: ;
		endcase
		expand_round_keys();
	endtask

	task automatic load_key(input logic [63:0] hi, input logic [63:0] lo);
		wait_drained();
		write_key_reg(ADDR_KEY_HIGH, hi);
		write_key_reg(ADDR_KEY_LOW, lo);
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------
	// all-zero key straight out of reset
	task automatic test_reset_key();
		send_block(MODE_ENCRYPT, '0, '0);
		send_block(MODE_DECRYPT, '0, '0);
		send_block(MODE_ENCRYPT, '1, '1);
		send_block(MODE_DECRYPT, '1, '1);
		send_round_trip(64'h0123456789ABCDEF, 64'hFEDCBA9876543210);
	endtask

	// key extremes, one register changed on its own
	task automatic test_key_extremes();
		load_key('1, '1);
		send_block(MODE_ENCRYPT, '0, '0);
		send_block(MODE_DECRYPT, '1, '1);
		send_round_trip(64'h8000000000000001, 64'h7FFFFFFFFFFFFFFE);
		load_key(64'h0123456789ABCDEF, 64'hFEDCBA9876543210);
		send_round_trip(64'h0123456789ABCDEF, 64'hFEDCBA9876543210);
		wait_drained();
		write_key_reg(ADDR_KEY_HIGH, '0);
		send_block(MODE_ENCRYPT, 64'hAAAAAAAAAAAAAAAA, 64'h5555555555555555);
		send_block(MODE_DECRYPT, 64'h5555555555555555, 64'hAAAAAAAAAAAAAAAA);
		wait_drained();
		write_key_reg(ADDR_KEY_LOW, '0);
		send_round_trip('1, '0);
	endtask

	// random traffic under a few keys; one pick in four is an encrypt/decrypt pair
	task automatic test_random_traffic(input int unsigned idle_pct,
			input int unsigned stall_in, input int n_blocks);
		int sent;
		wait_drained();
		send_idle_pct = idle_pct;
		stall_pct = stall_in;
		sent = 0;
		for (int epoch = 0; epoch < 3; epoch++) begin
			wait_drained();
			case ($urandom_range(3))
				0: write_key_reg(ADDR_KEY_HIGH, rand_half());
				1: write_key_reg(ADDR_KEY_LOW, rand_half());
				default: begin
					write_key_reg(ADDR_KEY_HIGH, rand_half());
					write_key_reg(ADDR_KEY_LOW, rand_half());
				end
			endcase
			while (sent < (n_blocks * (epoch + 1)) / 3) begin
				if ($urandom_range(3) == 0) begin
					send_round_trip(rand_half(), rand_half());
					sent += 2;
				end else begin
					send_block(1'($urandom_range(1)), rand_half(), rand_half());
					sent++;
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		data_valid = 1'b0;
		mode = MODE_ENCRYPT;
		data_high = '0;
		data_low = '0;
		result_stall = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = ADDR_KEY_HIGH;
		pwdata = '0;
		key_high_q = '0;
		key_low_q = '0;
		expand_round_keys();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_key();
		test_key_extremes();
		test_random_traffic(0, 0, 420);
		test_random_traffic(57, 0, 420);
		test_random_traffic(0, 57, 420);
		test_random_traffic(17, 17, 420);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("PASS sm4_block_cipher_custom_sbox");
		else
			$display("FAIL sm4_block_cipher_custom_sbox");
		$finish;
	end

endmodule

@@ sm4_block_cipher_custom_sbox.f @@
hw/rtl/sm4_pkg.sv
hw/rtl/sm4_round.sv
hw/rtl/sm4_key_sched.sv
hw/rtl/sm4_block_cipher_custom_sbox.sv
dv/sm4_block_cipher_custom_sbox_tb.sv
